// File: rtl/gshare_btb_return_stack_predictor_top_defines.svh
// Assertion macros shared by the predictor RTL.
`ifndef GSHARE_BTB_RETURN_STACK_PREDICTOR_TOP_DEFINES_SVH
`define GSHARE_BTB_RETURN_STACK_PREDICTOR_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define GBRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("predictor assertion failed");

// Antecedent implies consequent in the following cycle.
`define GBRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("predictor assertion failed");

`endif

// File: rtl/gbrs_pkg.sv
// Types and constants shared by the branch predictor modules.
`timescale 1ns / 1ps

package gbrs_pkg;

  localparam int INDEX_BITS_DEF  = 10;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int ADDR_BITS_DEF   = 48;

  localparam int FIELD_AW = 48;
  localparam int EXT_W    = 64;

  localparam logic MODE_PREDICT = 1'b0;
  localparam logic MODE_UPDATE  = 1'b1;

  typedef enum logic [1:0] {
    KIND_COND = 2'd0,
    KIND_CALL = 2'd1,
    KIND_JUMP = 2'd2,
    KIND_RET  = 2'd3
  } kind_e;

  typedef struct packed {
    logic                mode;
    logic [FIELD_AW-1:0] pc;
    logic [1:0]          kind;
    logic [3:0]          inst_length;
    logic [FIELD_AW-1:0] actual_target;
    logic                was_correct;
  } req_t;

  typedef struct packed {
    logic                predict_taken;
    logic [FIELD_AW-1:0] predict_target;
  } rsp_t;

endpackage

// File: rtl/gbrs_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module gbrs_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gshare_btb_return_stack_predictor_top.sv
// Top level of the gshare branch predictor with target buffer and return stack.
// Usage: a request enters on in_valid_i / in_req_i and is taken at an edge where
// in_stall_o is low. It is either a prediction or an update after resolution.
// Every request yields exactly one response on out_valid_o / out_rsp_o, taken
// at an edge where out_stall_i is low. Update requests answer not taken, zero.
// The request edge issues the reads of the counter and target buffer memories,
// while the return stack sits in registers; the write-back edge, taken once the
// output register is free, modifies and writes back the state and loads the
// output.
// A new request is not taken until the last one has written back its state, set
// by that read then write-back turn on the state memories.
// Reset: control registers and the return stack clear at once; then a clearing
// pass zeroes all 2**INDEX_BITS entries (1024 by default) of the counter and
// target buffer memories, with in_stall_o held high throughout.
// Stall: while a response waits under out_stall_i, one further request can be
// taken; it then waits in its write-back cycle until the output register frees.
`timescale 1ns / 1ps
`include "gshare_btb_return_stack_predictor_top_defines.svh"

module gshare_btb_return_stack_predictor_top #(
  parameter int INDEX_BITS  = gbrs_pkg::INDEX_BITS_DEF,
  parameter int STACK_DEPTH = gbrs_pkg::STACK_DEPTH_DEF,
  parameter int ADDR_BITS   = gbrs_pkg::ADDR_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gbrs_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gbrs_pkg::rsp_t out_rsp_o
);

  localparam int TABLE   = 2 ** INDEX_BITS;
  localparam int SP_W    = $clog2(STACK_DEPTH);
  localparam int HALF    = STACK_DEPTH / 2;
  localparam int WR_W    = $clog2(HALF + 2);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                  state_q;
  logic [INDEX_BITS-1:0]   clr_q;
  gbrs_pkg::req_t          item_q;
  logic [INDEX_BITS-1:0]   hist_q, hist_d;
  logic [SP_W-1:0]         sp_q, sp_d;
  logic                    empty_q, empty_d;
  logic [WR_W-1:0]         wrong_q, wrong_d, wrong_inc;
  logic                    out_valid_q;
  gbrs_pkg::rsp_t          out_q, rsp_d;
  logic [ADDR_BITS-1:0]    rs_q [STACK_DEPTH];

  logic                    accept, fin;
  logic [1:0]              ctr_rdata, ctr_new;
  logic [ADDR_BITS-1:0]    tb_rdata, rs_rdata;
  logic                    ctr_we, tb_we, rs_we;
  logic                    ctr_we_x, tb_we_x;
  logic [INDEX_BITS-1:0]   bslot, cslot, ctr_addr, tb_addr;
  logic [SP_W-1:0]         push_sp, rs_waddr;
  logic [1:0]              ctr_wdata;
  logic [ADDR_BITS-1:0]    tb_wdata;
  logic [gbrs_pkg::EXT_W-1:0] pc_ext, act_ext, tgt_ext;
  logic [ADDR_BITS-1:0]    pc_a, act_a, ret_addr, target;
  logic                    taken;

  assign accept      = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign fin         = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign pc_ext   = gbrs_pkg::EXT_W'(item_q.pc);
  assign act_ext  = gbrs_pkg::EXT_W'(item_q.actual_target);
  assign pc_a     = pc_ext[ADDR_BITS-1:0];
  assign act_a    = act_ext[ADDR_BITS-1:0];
  assign ret_addr = pc_a + ADDR_BITS'(item_q.inst_length);
  assign bslot    = item_q.pc[INDEX_BITS-1:0];
  assign cslot    = item_q.pc[INDEX_BITS-1:0] ^ hist_q;
  assign rs_rdata = rs_q[sp_q];
  assign wrong_inc = wrong_q + WR_W'(1);
  assign push_sp  = empty_q ? '0 :
                    ((sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + SP_W'(1));
  assign ctr_new  = item_q.was_correct ? ((ctr_rdata == 2'b11) ? ctr_rdata : ctr_rdata + 2'd1)
                                       : ((ctr_rdata == 2'b00) ? ctr_rdata : ctr_rdata - 2'd1);

  always_comb begin
    ctr_we   = 1'b0;
    tb_we    = 1'b0;
    rs_we    = 1'b0;
    rs_waddr = push_sp;
    hist_d   = hist_q;
    sp_d     = sp_q;
    empty_d  = empty_q;
    wrong_d  = wrong_q;
    taken    = 1'b0;
    target   = '0;
    if (item_q.mode == gbrs_pkg::MODE_PREDICT) begin
      unique case (item_q.kind)
        gbrs_pkg::KIND_CALL, gbrs_pkg::KIND_JUMP: begin
          taken  = 1'b1;
          target = tb_rdata;
        end
        gbrs_pkg::KIND_RET: begin
          taken = 1'b1;
          if (!empty_q) begin
            target = rs_rdata;
            sp_d   = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - SP_W'(1);
          end
        end
        default: begin
          if (ctr_rdata[1]) begin
            taken  = 1'b1;
            target = tb_rdata;
          end
        end
      endcase
    end else begin
      unique case (item_q.kind)
        gbrs_pkg::KIND_COND: begin
          ctr_we = 1'b1;
          tb_we  = 1'b1;
          hist_d = {hist_q[INDEX_BITS-2:0], item_q.was_correct};
        end
        gbrs_pkg::KIND_CALL: begin
          tb_we   = 1'b1;
          rs_we   = 1'b1;
          sp_d    = push_sp;
          empty_d = 1'b0;
        end
        gbrs_pkg::KIND_RET: begin
          if (!item_q.was_correct) begin
            wrong_d = wrong_inc;
            if (wrong_inc > WR_W'(HALF)) begin
              empty_d = 1'b1;
              sp_d    = '0;
              wrong_d = '0;
            end
          end
        end
        default: begin
          tb_we = 1'b1;
        end
      endcase
    end
    tgt_ext = '0;
    tgt_ext[ADDR_BITS-1:0] = target;
    rsp_d.predict_taken  = taken;
    rsp_d.predict_target = tgt_ext[gbrs_pkg::FIELD_AW-1:0];
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      ctr_we_x  = 1'b1;
      tb_we_x   = 1'b1;
      ctr_addr  = clr_q;
      tb_addr   = clr_q;
      ctr_wdata = '0;
      tb_wdata  = '0;
    end else begin
      ctr_we_x  = fin && ctr_we;
      tb_we_x   = fin && tb_we;
      ctr_addr  = cslot;
      tb_addr   = bslot;
      ctr_wdata = ctr_new;
      tb_wdata  = act_a;
    end
  end

  gbrs_ram #(.DEPTH(TABLE), .AW(INDEX_BITS), .DW(2)) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (ctr_we_x),
    .waddr_i (ctr_addr),
    .wdata_i (ctr_wdata),
    .re_i    (accept),
    .raddr_i (in_req_i.pc[INDEX_BITS-1:0] ^ hist_q),
    .rdata_o (ctr_rdata)
  );

  gbrs_ram #(.DEPTH(TABLE), .AW(INDEX_BITS), .DW(ADDR_BITS)) u_tb_ram (
    .clk_i   (clk_i),
    .we_i    (tb_we_x),
    .waddr_i (tb_addr),
    .wdata_i (tb_wdata),
    .re_i    (accept),
    .raddr_i (in_req_i.pc[INDEX_BITS-1:0]),
    .rdata_o (tb_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      item_q      <= '0;
      hist_q      <= '0;
      sp_q        <= '0;
      empty_q     <= 1'b1;
      wrong_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        rs_q[i] <= '0;
      end
    end else begin
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + INDEX_BITS'(1);
          if (clr_q == INDEX_BITS'(TABLE - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_req_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fin) begin
            hist_q      <= hist_d;
            sp_q        <= sp_d;
            empty_q     <= empty_d;
            wrong_q     <= wrong_d;
            out_q       <= rsp_d;
            state_q     <= ST_IDLE;
            if (rs_we) begin
              rs_q[rs_waddr] <= ret_addr;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `GBRS_ASSERT_NEXT(a_accept_to_exec, clk_i, rst_ni, accept, state_q == ST_EXEC)
  `GBRS_ASSERT_NEXT(a_finish_gives_response, clk_i, rst_ni, fin, out_valid_o)
  `GBRS_ASSERT_IMPL(a_empty_stack_at_bottom, clk_i, rst_ni, empty_q, sp_q == '0)
  `GBRS_ASSERT_IMPL(a_wrong_count_bound, clk_i, rst_ni, 1'b1, wrong_q <= WR_W'(HALF))

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the gshare predictor with target buffer and return stack.
`timescale 1ns / 1ps
module testbench;

  localparam int IB = gbrs_pkg::INDEX_BITS_DEF;
  localparam int SD = gbrs_pkg::STACK_DEPTH_DEF;
  localparam int AW = gbrs_pkg::FIELD_AW;
  localparam int TABLE_SIZE = 1 << IB;
  localparam int ITEMS = 900;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [AW-1:0] ADDR_ONES = '1;

  typedef struct {
    gbrs_pkg::req_t req;
    bit             typed;
    gbrs_pkg::rsp_t rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  gbrs_pkg::req_t in_req = '0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  gbrs_pkg::rsp_t out_rsp_o;

  always #4 clk_i = ~clk_i;

  gshare_btb_return_stack_predictor_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp_o)
  );

  logic [IB-1:0] ghist;
  logic [1:0]    dir_ctr [TABLE_SIZE];
  logic [AW-1:0] tgt_buf [TABLE_SIZE];
  logic [AW-1:0] ret_stack [SD];
  int unsigned   ret_sp;
  int unsigned   wrong_rets;
  bit            ret_empty;

  gbrs_pkg::rsp_t pending_predictions [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit          flood = 1'b0;
  bit          hold_done = 1'b0;

  function automatic gbrs_pkg::rsp_t predict_branch(input gbrs_pkg::req_t r);
    gbrs_pkg::rsp_t res;
    logic [IB-1:0] bslot;
    logic [IB-1:0] cslot;
    logic [1:0]    ctr;
    res = '0;
    bslot = r.pc[IB-1:0];
    cslot = bslot ^ ghist;
    if (r.mode == gbrs_pkg::MODE_PREDICT) begin
      case (r.kind)
        gbrs_pkg::KIND_CALL, gbrs_pkg::KIND_JUMP: begin
          res.predict_taken = 1'b1;
          res.predict_target = tgt_buf[bslot];
        end
        gbrs_pkg::KIND_RET: begin
          res.predict_taken = 1'b1;
          if (!ret_empty) begin
            res.predict_target = ret_stack[ret_sp];
            ret_sp = (ret_sp == 0) ? SD - 1 : ret_sp - 1;
          end
        end
        gbrs_pkg::KIND_COND: begin
          if (dir_ctr[cslot] >= 2'd2) begin
            res.predict_taken = 1'b1;
            res.predict_target = tgt_buf[bslot];
          end
        end
      endcase
    end else begin
      case (r.kind)
        gbrs_pkg::KIND_COND: begin
          ctr = dir_ctr[cslot];
          if (r.was_correct) begin
            if (ctr != 2'd3) ctr++;
          end else if (ctr != 2'd0) begin
            ctr--;
          end
          dir_ctr[cslot] = ctr;
          ghist = {ghist[IB-2:0], r.was_correct};
          tgt_buf[bslot] = r.actual_target;
        end
        gbrs_pkg::KIND_CALL: begin
          ret_sp = ret_empty ? 0 : (ret_sp + 1) % SD;
          ret_empty = 1'b0;
          ret_stack[ret_sp] = r.pc + AW'(r.inst_length);
          tgt_buf[bslot] = r.actual_target;
        end
        gbrs_pkg::KIND_RET: begin
          if (!r.was_correct) begin
            wrong_rets++;
            if (wrong_rets > SD / 2) begin
              ret_empty = 1'b1;
              ret_sp = 0;
              wrong_rets = 0;
            end
          end
        end
        gbrs_pkg::KIND_JUMP: begin
          tgt_buf[bslot] = r.actual_target;
        end
      endcase
    end
    return res;
  endfunction

  function automatic gbrs_pkg::req_t branch_req(input logic mode, input logic [AW-1:0] pc,
                                                input gbrs_pkg::kind_e kind,
                                                input logic [3:0] len,
                                                input logic [AW-1:0] actual,
                                                input logic correct);
    gbrs_pkg::req_t r;
    r.mode = mode;
    r.pc = pc;
    r.kind = kind;
    r.inst_length = len;
    r.actual_target = actual;
    r.was_correct = correct;
    return r;
  endfunction

  function automatic logic [AW-1:0] rand_addr();
    return AW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [3:0] rand_len();
    return 4'($urandom_range(1, 15));
  endfunction

  task automatic add_row(input gbrs_pkg::req_t r, input bit typed, input logic taken,
                         input logic [AW-1:0] target);
    stim_row_t row;
    row.req = r;
    row.typed = typed;
    row.rsp.predict_taken = taken;
    row.rsp.predict_target = target;
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input logic [AW-1:0] got,
                                 input logic [AW-1:0] want);
    if (mismatches < 100)
      $display("mismatch on %s at cycle %0d: got %h, expected %h", what, cycles, got, want);
    mismatches++;
  endtask

  task automatic offer(input gbrs_pkg::req_t r, input bit typed,
                       input gbrs_pkg::rsp_t typed_rsp);
    gbrs_pkg::rsp_t predicted;
    flood = (sent >= 300 && sent < 450);
    if (!flood) begin
      while ($urandom_range(0, 99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_branch(r);
    pending_predictions.push_back(typed ? typed_rsp : predicted);
    sent++;
  endtask

  task automatic send(input gbrs_pkg::req_t r);
    offer(r, 1'b0, '0);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent >= 650) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !flood && ($urandom_range(0, 99) < 36);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    gbrs_pkg::rsp_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_predictions.size() == 0) begin
        report_mismatch("response with no request outstanding", out_rsp_o.predict_target, '0);
      end else begin
        want = pending_predictions.pop_front();
        if (out_rsp_o.predict_taken !== want.predict_taken)
          report_mismatch("predict_taken", AW'(out_rsp_o.predict_taken),
                          AW'(want.predict_taken));
        if (out_rsp_o.predict_target !== want.predict_target)
          report_mismatch("predict_target", out_rsp_o.predict_target, want.predict_target);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [AW-1:0] pool [6];
    logic [AW-1:0] pc;
    int            n;
    int            m;
    logic          bias;
    ghist = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      dir_ctr[i] = 2'd0;
      tgt_buf[i] = '0;
    end
    for (int i = 0; i < SD; i++) ret_stack[i] = '0;
    ret_sp = 0;
    ret_empty = 1'b1;
    wrong_rets = 0;

    add_row(branch_req(gbrs_pkg::MODE_PREDICT, '0, gbrs_pkg::KIND_COND, 4'd1, '0, 1'b0),
            1'b1, 1'b0, '0);
    add_row(branch_req(gbrs_pkg::MODE_PREDICT, ADDR_ONES, gbrs_pkg::KIND_COND, 4'd15,
                       ADDR_ONES, 1'b1), 1'b1, 1'b0, '0);
    add_row(branch_req(gbrs_pkg::MODE_PREDICT, 48'h1234_5678_9abc, gbrs_pkg::KIND_RET, 4'd4,
                       '0, 1'b0), 1'b1, 1'b1, '0);
    add_row(branch_req(gbrs_pkg::MODE_PREDICT, ADDR_ONES, gbrs_pkg::KIND_JUMP, 4'd2, '0, 1'b0),
            1'b1, 1'b1, '0);
    add_row(branch_req(gbrs_pkg::MODE_UPDATE, ADDR_ONES, gbrs_pkg::KIND_JUMP, 4'd2, ADDR_ONES,
                       1'b0), 1'b1, 1'b0, '0);
    add_row(branch_req(gbrs_pkg::MODE_PREDICT, 48'h0000_0000_03ff, gbrs_pkg::KIND_CALL, 4'd5,
                       '0, 1'b0), 1'b1, 1'b1, ADDR_ONES);
    add_row(branch_req(gbrs_pkg::MODE_UPDATE, ADDR_ONES, gbrs_pkg::KIND_CALL, 4'd15, '0, 1'b1),
            1'b1, 1'b0, '0);
    add_row(branch_req(gbrs_pkg::MODE_PREDICT, 48'h5555_0000_0010, gbrs_pkg::KIND_RET, 4'd3,
                       '0, 1'b0), 1'b1, 1'b1, 48'd14);
    add_row(branch_req(gbrs_pkg::MODE_PREDICT, 48'h5555_0000_0020, gbrs_pkg::KIND_RET, 4'd3,
                       '0, 1'b0), 1'b1, 1'b1, '0);
    add_row(branch_req(gbrs_pkg::MODE_UPDATE, 48'h0000_0000_0005, gbrs_pkg::KIND_COND, 4'd2,
                       48'haaaa_5555_aaaa, 1'b1), 1'b1, 1'b0, '0);
    add_row(branch_req(gbrs_pkg::MODE_UPDATE, 48'h8000_0000_0004, gbrs_pkg::KIND_COND, 4'd2,
                       48'h0f0f_f0f0_0f0f, 1'b1), 1'b1, 1'b0, '0);
    add_row(branch_req(gbrs_pkg::MODE_PREDICT, 48'h0000_0000_0006, gbrs_pkg::KIND_COND, 4'd2,
                       '0, 1'b0), 1'b0, 1'b0, '0);
    add_row(branch_req(gbrs_pkg::MODE_PREDICT, 48'h0000_0000_0005, gbrs_pkg::KIND_COND, 4'd2,
                       '0, 1'b0), 1'b0, 1'b0, '0);
    add_row(branch_req(gbrs_pkg::MODE_UPDATE, 48'h0000_0000_0005, gbrs_pkg::KIND_COND, 4'd2,
                       48'h0000_0000_1234, 1'b0), 1'b0, 1'b0, '0);
    add_row(branch_req(gbrs_pkg::MODE_UPDATE, 48'h0000_0000_0100, gbrs_pkg::KIND_RET, 4'd1,
                       '0, 1'b1), 1'b1, 1'b0, '0);
    for (int i = 0; i < SD / 2 + 1; i++)
      add_row(branch_req(gbrs_pkg::MODE_UPDATE, 48'h0000_0000_0100, gbrs_pkg::KIND_RET, 4'd1,
                         '0, 1'b0), 1'b1, 1'b0, '0);
    add_row(branch_req(gbrs_pkg::MODE_PREDICT, 48'h0000_0000_0200, gbrs_pkg::KIND_RET, 4'd1,
                       '0, 1'b0), 1'b1, 1'b1, '0);

    for (int i = 0; i < 6; i++) pool[i] = rand_addr();
    pool[0][IB-1:0] = '0;
    pool[1][IB-1:0] = 10'd1;
    pool[2][IB-1:0] = 10'd3;
    pool[3][IB-1:0] = 10'h200;
    pool[4][IB-1:0] = 10'h3ff;
    pool[5] = ADDR_ONES;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

    while (sent < ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(1, 8);
          bias = 1'($urandom_range(0, 1));
          repeat (n) begin
            pc = pool[$urandom_range(0, 5)];
            send(branch_req(gbrs_pkg::MODE_PREDICT, pc, gbrs_pkg::KIND_COND, rand_len(),
                            rand_addr(), 1'($urandom_range(0, 1))));
            send(branch_req(gbrs_pkg::MODE_UPDATE, pc, gbrs_pkg::KIND_COND, rand_len(),
                            rand_addr(), ($urandom_range(0, 99) < 80) ? bias : ~bias));
          end
        end
        3, 4: begin
          n = $urandom_range(1, 20);
          repeat (n)
            send(branch_req(gbrs_pkg::MODE_UPDATE, rand_addr(), gbrs_pkg::KIND_CALL,
                            rand_len(), rand_addr(), 1'($urandom_range(0, 1))));
          m = $urandom_range(0, n + 2);
          repeat (m) begin
            send(branch_req(gbrs_pkg::MODE_PREDICT, rand_addr(), gbrs_pkg::KIND_RET,
                            rand_len(), rand_addr(), 1'($urandom_range(0, 1))));
            send(branch_req(gbrs_pkg::MODE_UPDATE, rand_addr(), gbrs_pkg::KIND_RET,
                            rand_len(), rand_addr(), $urandom_range(0, 99) < 75));
          end
        end
        5: begin
          n = $urandom_range(1, 10);
          repeat (n)
            send(branch_req(gbrs_pkg::MODE_UPDATE, rand_addr(), gbrs_pkg::KIND_RET,
                            rand_len(), rand_addr(), 1'b0));
        end
        6: begin
          pc = ($urandom_range(0, 1) != 0) ? pool[$urandom_range(0, 5)] : rand_addr();
          send(branch_req(gbrs_pkg::MODE_UPDATE, pc, gbrs_pkg::KIND_JUMP, rand_len(),
                          rand_addr(), 1'($urandom_range(0, 1))));
          send(branch_req(gbrs_pkg::MODE_PREDICT, pc,
                          ($urandom_range(0, 1) != 0) ? gbrs_pkg::KIND_JUMP
                                                      : gbrs_pkg::KIND_CALL,
                          rand_len(), rand_addr(), 1'($urandom_range(0, 1))));
        end
        default: begin
          send(branch_req(1'($urandom_range(0, 1)), rand_addr(),
                          gbrs_pkg::kind_e'($urandom_range(0, 3)), rand_len(), rand_addr(),
                          1'($urandom_range(0, 1))));
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending_predictions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/gbrs_pkg.sv
rtl/gbrs_ram.sv
rtl/gshare_btb_return_stack_predictor_top.sv
tb/testbench.sv
